@@ rtl/conv3x3_image_filter_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the 3x3 image filter core
// Concurrent assertion shorthands, all clocked on clock.
// ---------------------------------------------------------------------------
`ifndef CONV3X3_IMAGE_FILTER_CORE_ASSERT_SVH
`define CONV3X3_IMAGE_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, switched off while reset is high
`define C3F_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high
`define C3F_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds through reset
`define C3F_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/c3f_pkg.sv @@
// ---------------------------------------------------------------------------
// c3f_pkg
// Shared constants and types of the 3x3 image filter core.
// ---------------------------------------------------------------------------
package c3f_pkg;

   // Frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Field widths
   localparam int SIZE_W     = 11;
   localparam int MODE_W     = 3;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 10;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE  = 2'd2;

   // Register reset values
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd512;
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;

   // Filter modes
   localparam logic [MODE_W-1:0] MODE_PREWITT_X = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PREWITT_Y = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SOBEL_X   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SOBEL_Y   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LAPLACE   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_GAUSS     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_BOX       = 3'd6;

   // Frame size as programmed
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } c3f_size_type;

   // One 3x3 neighbourhood, pix[r*3+c], r top..bottom, c left..right
   typedef struct packed {
      logic [8:0][PIX_W-1:0] pix;
      logic [COORD_W-1:0]    col;
      logic [COORD_W-1:0]    row;
      logic                  last;
   } c3f_win_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic              head_valid;
      logic [QCNT_W-1:0] count;
   } c3f_qstat_type;

endpackage

@@ rtl/c3f_queue.sv @@
// ---------------------------------------------------------------------------
// c3f_queue
// Short FIFO of filter windows between the front and the back.
// ---------------------------------------------------------------------------
module c3f_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  c3f_pkg::c3f_win_type  push_data,
   input  logic                  pop,
   output c3f_pkg::c3f_win_type  head_data,
   output c3f_pkg::c3f_qstat_type qstat
);
   import c3f_pkg::*;

   c3f_win_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = entry_ff[rd_ptr_ff];
   assign qstat.head_valid = (count_ff != '0);
   assign qstat.count      = count_ff;

endmodule

@@ rtl/c3f_front.sv @@
// ---------------------------------------------------------------------------
// c3f_front
// Pixel intake: position counters, two row stores and the sliding window.
// Classifies each pixel and pushes a full window for interior centres.
// ---------------------------------------------------------------------------
module c3f_front (
   input  logic                         clock,
   input  logic                         reset,
   input  c3f_pkg::c3f_size_type        size,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [c3f_pkg::PIX_W-1:0]    req_tdata,
   input  c3f_pkg::c3f_qstat_type       qstat,
   output logic                         push,
   output c3f_pkg::c3f_win_type         push_data
);
   import c3f_pkg::*;

   // Row stores
   logic [PIX_W-1:0] row_upper_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] row_middle_ff [MAX_WIDTH];

   // Position and fill count
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W:0]    fill_ff, fill_in;

   // Stage 1 (read data returns)
   logic              s1_valid_ff;
   logic              s1_emit_ff;
   logic              s1_fill_ok_ff;
   logic [COL_W-1:0]  s1_addr_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic              s1_last_ff;
   logic [PIX_W-1:0]  up_rd_ff;
   logic [PIX_W-1:0]  mid_rd_ff;

   // Window: left column 0..2, middle column 3..5, top to bottom
   logic [PIX_W-1:0]  win_ff [6];

   logic [SIZE_W-1:0] width_eff, height_eff;
   logic [SIZE_W-1:0] col_ext, row_ext;
   logic              fire, emit, last;
   logic              s1_push;
   logic [PIX_W-1:0]  up_val, mid_val;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v < SIZE_W'(3)) begin
         r = SIZE_W'(3);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

   assign width_eff  = clamp_size(size.width,  SIZE_W'(MAX_WIDTH));
   assign height_eff = clamp_size(size.height, SIZE_W'(MAX_HEIGHT));
   assign col_ext    = SIZE_W'(col_ff);
   assign row_ext    = SIZE_W'(row_ff);

   // Accept only when the queue can take what is in flight plus this one
   assign s1_push    = s1_valid_ff && s1_emit_ff;
   assign req_tready = ((QCNT_W+1)'(qstat.count) + (QCNT_W+1)'(s1_push))
                       < (QCNT_W+1)'(QUEUE_DEPTH);
   assign fire       = req_tvalid && req_tready;

   // Classification of the incoming pixel
   assign emit = (row_ext >= SIZE_W'(2)) && (col_ext >= SIZE_W'(2))
              && (row_ext < height_eff) && (col_ext < width_eff);
   assign last = (row_ext == height_eff - 1'b1) && (col_ext == width_eff - 1'b1);

   // Raster position and fill count
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      fill_in = fill_ff;
      if (fire) begin
         if (col_ext + 1'b1 >= width_eff) begin
            col_in = '0;
            row_in = (row_ext + 1'b1 >= height_eff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
         if ((COL_W+1)'(col_ff) == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         fill_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         fill_ff     <= fill_in;
         s1_valid_ff <= fire;
         s1_emit_ff  <= fire && emit;
      end
   end

   // Stage 1 payload
   always_ff @(posedge clock) begin
      if (fire) begin
         s1_fill_ok_ff <= (COL_W+1)'(col_ff) < fill_ff;
         s1_addr_ff    <= col_ff;
         s1_pix_ff     <= req_tdata;
         s1_col_ff     <= COORD_W'(col_ff - 1'b1);
         s1_row_ff     <= COORD_W'(row_ff - 1'b1);
         s1_last_ff    <= last;
      end
   end

   // Middle store: read old value and write the new pixel in one go
   always_ff @(posedge clock) begin
      if (fire) begin
         mid_rd_ff              <= row_middle_ff[col_ff];
         row_middle_ff[col_ff]  <= req_tdata;
      end
   end

   // Entries past the fill count have never been written and read as zero
   assign up_val  = s1_fill_ok_ff ? up_rd_ff  : '0;
   assign mid_val = s1_fill_ok_ff ? mid_rd_ff : '0;

   // Upper store: read at intake, middle row moves up in the following cycle
   always_ff @(posedge clock) begin
      if (fire) begin
         up_rd_ff <= row_upper_ff[col_ff];
      end
      if (s1_valid_ff) begin
         row_upper_ff[s1_addr_ff] <= mid_val;
      end
   end

   // Window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_val;
         win_ff[4] <= mid_val;
         win_ff[5] <= s1_pix_ff;
      end
   end

   // Window to the queue, row-major
   assign push              = s1_push;
   assign push_data.pix[0]  = win_ff[0];
   assign push_data.pix[1]  = win_ff[3];
   assign push_data.pix[2]  = up_val;
   assign push_data.pix[3]  = win_ff[1];
   assign push_data.pix[4]  = win_ff[4];
   assign push_data.pix[5]  = mid_val;
   assign push_data.pix[6]  = win_ff[2];
   assign push_data.pix[7]  = win_ff[5];
   assign push_data.pix[8]  = s1_pix_ff;
   assign push_data.col     = s1_col_ff;
   assign push_data.row     = s1_row_ff;
   assign push_data.last    = s1_last_ff;

endmodule

@@ rtl/c3f_back.sv @@
// ---------------------------------------------------------------------------
// c3f_back
// Filter datapath: weighted sums, then scaling and the output register.
// ---------------------------------------------------------------------------
module c3f_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [c3f_pkg::MODE_W-1:0]      mode,
   input  c3f_pkg::c3f_qstat_type          qstat,
   input  c3f_pkg::c3f_win_type            head_data,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [c3f_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast
);
   import c3f_pkg::*;

   // Scaling applied in the second stage
   typedef enum logic [2:0] {
      OP_ZERO,
      OP_DIV3,
      OP_SHR2,
      OP_CLAMP,
      OP_SHR4,
      OP_BOX
   } c3f_op_type;

   // Reciprocals: x/3 = x*43691 >> 17, x/9 = x*7282 >> 16 (exact in range)
   localparam logic [15:0] RECIP3 = 16'd43691;
   localparam logic [15:0] RECIP9 = 16'd7282;

   logic [PIX_W-1:0]    q [9];
   logic [9:0]          sa, sb, diff;
   logic [11:0]         sum8, centre9, gauss, sum9;
   logic signed [12:0]  a_val_in;
   c3f_op_type          a_op_in;

   logic                a_valid_ff;
   logic signed [12:0]  a_val_ff;
   c3f_op_type          a_op_ff;
   logic [COORD_W-1:0]  a_col_ff, a_row_ff;
   logic                a_last_ff;

   logic                rsp_valid_ff;
   logic [PIX_W-1:0]    rsp_pix_ff, res;
   logic [COORD_W-1:0]  rsp_col_ff, rsp_row_ff;
   logic                rsp_last_ff;

   logic [15:0]         mult_const;
   logic [27:0]         prod;
   logic                en_a, en_b;

   // Pipeline advance
   assign en_b = !rsp_valid_ff || rsp_tready;
   assign en_a = !a_valid_ff || en_b;
   assign pop  = qstat.head_valid && en_a;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         q[i] = head_data.pix[i];
      end
   end

   // Shared sums
   assign sum8 = 12'(q[0]) + 12'(q[1]) + 12'(q[2]) + 12'(q[3])
               + 12'(q[5]) + 12'(q[6]) + 12'(q[7]) + 12'(q[8]);
   assign centre9 = (12'(q[4]) << 3) + 12'(q[4]);
   assign sum9    = sum8 + 12'(q[4]);
   assign gauss   = 12'(q[0]) + 12'(q[2]) + 12'(q[6]) + 12'(q[8])
                  + ((12'(q[1]) + 12'(q[3]) + 12'(q[5]) + 12'(q[7])) << 1)
                  + (12'(q[4]) << 2);

   // Gradient operands per mode
   always_comb begin
      sa = '0;
      sb = '0;
      unique case (mode)
         MODE_PREWITT_X: begin
            sa = 10'(q[2]) + 10'(q[5]) + 10'(q[8]);
            sb = 10'(q[0]) + 10'(q[3]) + 10'(q[6]);
         end
         MODE_PREWITT_Y: begin
            sa = 10'(q[6]) + 10'(q[7]) + 10'(q[8]);
            sb = 10'(q[0]) + 10'(q[1]) + 10'(q[2]);
         end
         MODE_SOBEL_X: begin
            sa = 10'(q[2]) + (10'(q[5]) << 1) + 10'(q[8]);
            sb = 10'(q[0]) + (10'(q[3]) << 1) + 10'(q[6]);
         end
         MODE_SOBEL_Y: begin
            sa = 10'(q[6]) + (10'(q[7]) << 1) + 10'(q[8]);
            sb = 10'(q[0]) + (10'(q[1]) << 1) + 10'(q[2]);
         end
         default: begin
            sa = '0;
            sb = '0;
         end
      endcase
   end

   assign diff = (sa >= sb) ? sa - sb : sb - sa;

   // Stage A value and scaling selection
   always_comb begin
      a_val_in = '0;
      a_op_in  = OP_ZERO;
      unique case (mode)
         MODE_PREWITT_X, MODE_PREWITT_Y: begin
            a_val_in = $signed(13'(diff));
            a_op_in  = OP_DIV3;
         end
         MODE_SOBEL_X, MODE_SOBEL_Y: begin
            a_val_in = $signed(13'(diff));
            a_op_in  = OP_SHR2;
         end
         MODE_LAPLACE: begin
            a_val_in = $signed({1'b0, centre9}) - $signed({1'b0, sum8});
            a_op_in  = OP_CLAMP;
         end
         MODE_GAUSS: begin
            a_val_in = $signed({1'b0, gauss});
            a_op_in  = OP_SHR4;
         end
         MODE_BOX: begin
            // floor(s*0.11111) equals floor((s-1)/9) for s >= 1
            if (sum9 != '0) begin
               a_val_in = $signed({1'b0, sum9 - 1'b1});
               a_op_in  = OP_BOX;
            end
         end
         default: begin
            a_val_in = '0;
            a_op_in  = OP_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= qstat.head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_val_ff  <= a_val_in;
         a_op_ff   <= a_op_in;
         a_col_ff  <= head_data.col;
         a_row_ff  <= head_data.row;
         a_last_ff <= head_data.last;
      end
   end

   // Stage B: one shared reciprocal multiplier
   assign mult_const = (a_op_ff == OP_DIV3) ? RECIP3 : RECIP9;
   assign prod       = a_val_ff[11:0] * mult_const;

   always_comb begin
      case (a_op_ff)
         OP_DIV3:  res = prod[24:17];
         OP_BOX:   res = prod[23:16];
         OP_SHR2:  res = a_val_ff[9:2];
         OP_SHR4:  res = a_val_ff[11:4];
         OP_CLAMP: begin
            if (a_val_ff < 0) begin
               res = '0;
            end else if (a_val_ff > 13'sd255) begin
               res = 8'd255;
            end else begin
               res = a_val_ff[7:0];
            end
         end
         default:  res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_b) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         rsp_pix_ff  <= res;
         rsp_col_ff  <= a_col_ff;
         rsp_row_ff  <= a_row_ff;
         rsp_last_ff <= a_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PIX_W - 2*COORD_W)'(0),
                        rsp_row_ff, rsp_col_ff, rsp_pix_ff};

endmodule

@@ rtl/conv3x3_image_filter_core.sv @@
// ---------------------------------------------------------------------------
// conv3x3_image_filter_core
// 3x3 convolution filter over a raster-order 8-bit grey pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one pixel per transaction, raster order, row 0 first.
//  - rsp_ channel: one transaction per interior pixel, in raster order, with
//    its filtered value and coordinates; border pixels produce nothing.
//    rsp_tlast marks the last interior pixel of the frame.
//  - csr_ channel: register writes (width, height, filter mode), always
//    ready; write only while no pixels are in flight.
//  - Path: after the pixel below and to the right of its centre is accepted,
//    its window passes the read stage, queue, stage A and output register.
//  - Throughput: one pixel per cycle while rsp_tready stays high; row store
//    read-modify-write and the two-stage datapath each take one pixel a cycle.
//  - Stall: a four-deep window queue decouples intake from the filter;
//    req_tready drops once the queued windows plus the one in the read
//    stage fill the queue, which only happens behind a held result.
//  - Reset: counters, queue and valids clear synchronously; the row stores
//    use a fill count, so unwritten entries read as zero with no sweep.
// ---------------------------------------------------------------------------
module conv3x3_image_filter_core (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel input
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [c3f_pkg::PIX_W-1:0]         req_tdata,  // [7:0] pixel_in
   // Filtered output
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] pixel_out, [17:8] out_col, [27:18] out_row, [31:28] zero
   output logic [c3f_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,  // frame_last
   // Register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [c3f_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [c3f_pkg::SIZE_W-1:0]        csr_data
);
   import c3f_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [MODE_W-1:0] mode_ff;

   c3f_size_type      size;
   c3f_qstat_type     qstat;
   c3f_win_type       push_data, head_data;
   logic              push, pop;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
         mode_ff   <= MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            CSR_FILTER_MODE:  mode_ff   <= csr_data[MODE_W-1:0];
            default: ;
         endcase
      end
   end

   assign size.width  = width_ff;
   assign size.height = height_ff;

   c3f_front u_front (
      .clock      (clock),
      .reset      (reset),
      .size       (size),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   c3f_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .head_data  (head_data),
      .qstat      (qstat)
   );

   c3f_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .qstat      (qstat),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/c3f_checker.sv @@
// ---------------------------------------------------------------------------
// c3f_checker
// Port-level checks on the filter core, attached by bind.
// ---------------------------------------------------------------------------
`include "conv3x3_image_filter_core_assert.svh"

module c3f_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [c3f_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            rsp_tlast
);

   // A held result keeps its payload
   `C3F_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // Reset empties the output register
   `C3F_ASSERT_NEXT_ALWAYS(a_rsp_reset, reset, !rsp_tvalid, "rsp valid right after reset")

   // Back-to-back results in one row step the column by one
   `C3F_ASSERT_SAME(a_col_step, (rsp_tvalid && rsp_tready && !rsp_tlast) ##1 (rsp_tvalid && rsp_tready && rsp_tdata[27:18] == $past(rsp_tdata[27:18])), rsp_tdata[17:8] == $past(rsp_tdata[17:8]) + 10'd1, "column sequence broken within a row")

endmodule

bind conv3x3_image_filter_core c3f_checker u_checker (.*);

@@ bench/conv3x3_image_filter_core_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv3x3_image_filter_core_tb
// Self-checking bench for the 3x3 image filter core. A queue of grey pixels
// feeds the req_ stream. Each accepted pixel goes through a bit-true
// predictor of the row stores, the window and the seven filters. Every rsp_
// transaction is checked in order against the expected filtered pixels.
// Register writes happen only with the pipeline drained. Frame sizes, modes
// and stalls on both sides are randomised per phase.
// ---------------------------------------------------------------------------
module conv3x3_image_filter_core_tb;
   import c3f_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [MODE_W-1:0]    MODE_UNUSED      = 3'd7;
   localparam int SETTLE_CYCLES  = 16;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int RANDOM_PIXELS  = 60;

   // One expected filtered pixel
   typedef struct {
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } filtered_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [SIZE_W-1:0]     csr_data = '0;

   // Stimulus and checking state
   logic [PIX_W-1:0]   pixel_backlog[$];
   filtered_pixel_type filtered_due[$];
   int unsigned      req_offered = 0;
   int unsigned      req_accepted = 0;
   int unsigned      failures = 0;
   int unsigned      cycle_count = 0;
   int unsigned      send_gap = 0;
   int unsigned      recv_stall = 0;
   int unsigned      send_gap_odds = 4;
   int unsigned      recv_stall_odds = 4;

   // Predictor state
   logic [SIZE_W-1:0] cfg_width  = SIZE_RESET;
   logic [SIZE_W-1:0] cfg_height = SIZE_RESET;
   logic [MODE_W-1:0] cfg_mode   = MODE_RESET;
   bit [PIX_W-1:0]    upper_row [MAX_WIDTH];
   bit [PIX_W-1:0]    middle_row [MAX_WIDTH];
   bit [PIX_W-1:0]    win [6];
   int unsigned       next_col = 0;
   int unsigned       next_row = 0;

   conv3x3_image_filter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int unsigned clamp_dim(input logic [SIZE_W-1:0] v,
                                             input int unsigned lim);
      if (v < 3) return 3;
      if (v > lim) return lim;
      return v;
   endfunction

   // nb[r*3+c], r top..bottom, c left..right
   function automatic logic [PIX_W-1:0] filter_value(input int nb[9],
                                                     input logic [MODE_W-1:0] mode);
      int s;
      int t;
      int v;
      v = 0;
      case (mode)
         MODE_PREWITT_X: begin
            s = nb[2] + nb[5] + nb[8];
            t = nb[0] + nb[3] + nb[6];
            v = ((s >= t) ? s - t : t - s) / 3;
         end
         MODE_PREWITT_Y: begin
            s = nb[6] + nb[7] + nb[8];
            t = nb[0] + nb[1] + nb[2];
            v = ((s >= t) ? s - t : t - s) / 3;
         end
         MODE_SOBEL_X: begin
            s = nb[2] + 2 * nb[5] + nb[8];
            t = nb[0] + 2 * nb[3] + nb[6];
            v = ((s >= t) ? s - t : t - s) / 4;
         end
         MODE_SOBEL_Y: begin
            s = nb[6] + 2 * nb[7] + nb[8];
            t = nb[0] + 2 * nb[1] + nb[2];
            v = ((s >= t) ? s - t : t - s) / 4;
         end
         MODE_LAPLACE: begin
            t = nb[0] + nb[1] + nb[2] + nb[3] + nb[5] + nb[6] + nb[7] + nb[8];
            s = 9 * nb[4] - t;
            v = (s < 0) ? 0 : ((s > 255) ? 255 : s);
         end
         MODE_GAUSS: begin
            s = nb[0] + nb[2] + nb[6] + nb[8]
              + 2 * (nb[1] + nb[3] + nb[5] + nb[7]) + 4 * nb[4];
            v = s >> 4;
         end
         MODE_BOX: begin
            s = nb[0] + nb[1] + nb[2] + nb[3] + nb[4] + nb[5] + nb[6] + nb[7] + nb[8];
            v = (s * 11111) / 100000;
         end
         default: v = 0;   // unused mode gives zero
      endcase
      return v[PIX_W-1:0];
   endfunction

   // Advance the line buffers and window by one pixel; queue a result for
   // an interior centre once its bottom-right neighbour is in
   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      int unsigned        w;
      int unsigned        h;
      int unsigned        c;
      int unsigned        r;
      logic [PIX_W-1:0]   above;
      logic [PIX_W-1:0]   middle;
      int                 nb[9];
      filtered_pixel_type res;
      w = clamp_dim(cfg_width, MAX_WIDTH);
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      c = next_col;
      r = next_row;
      above = '0;
      middle = '0;
      if (c < MAX_WIDTH) begin
         above = upper_row[c];
         middle = middle_row[c];
         upper_row[c] = middle;
         middle_row[c] = pix;
      end
      if (r >= 2 && c >= 2 && r < h && c < w) begin
         nb = '{win[0], win[3], above, win[1], win[4], middle, win[2], win[5], pix};
         res.value = filter_value(nb, cfg_mode);
         res.col = COORD_W'(c - 1);
         res.row = COORD_W'(r - 1);
         res.last = (r == h - 1) && (c == w - 1);
         filtered_due.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = above;
      win[4] = middle;
      win[5] = pix;
      // a position at or past the current size ends its row or frame
      if (c + 1 >= w) begin
         next_col = 0;
         next_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
   endtask

   // Pixel driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_offered == req_accepted) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_backlog.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (send_gap_odds != 0 && $urandom_range(0, send_gap_odds - 1) == 0) begin
            send_gap = $urandom_range(0, 18);
            req_tvalid <= 1'b0;
         end else begin
            req_tdata <= pixel_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_offered++;
         end
      end
   end

   // Result receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else if (recv_stall_odds != 0 && $urandom_range(0, recv_stall_odds - 1) == 0) begin
         recv_stall = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: register writes, accepted pixels and result checking
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width = csr_data;
               CSR_IMAGE_HEIGHT: cfg_height = csr_data;
               CSR_FILTER_MODE:  cfg_mode = csr_data[MODE_W-1:0];
               default: ;        // spare index is ignored
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_due.size() == 0) begin
               $error("unexpected result transaction: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               filtered_pixel_type want;
               want = filtered_due.pop_front();
               if (rsp_tdata[7:0] !== want.value) begin
                  $error("pixel_out: expected %0d, actual %0d", want.value, rsp_tdata[7:0]);
                  failures++;
               end
               if (rsp_tdata[17:8] !== want.col) begin
                  $error("out_col: expected %0d, actual %0d", want.col, rsp_tdata[17:8]);
                  failures++;
               end
               if (rsp_tdata[27:18] !== want.row) begin
                  $error("out_row: expected %0d, actual %0d", want.row, rsp_tdata[27:18]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_last: expected %0d, actual %0d", want.last, rsp_tlast);
                  failures++;
               end
               if (rsp_tdata[31:28] !== 4'd0) begin
                  $error("tdata padding: expected 0, actual %0d", rsp_tdata[31:28]);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            req_accepted++;
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("conv3x3_image_filter_core_tb: FAIL");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every pixel is in and every result is out
   task automatic wait_drained();
      while (pixel_backlog.size() != 0 || req_offered != req_accepted
             || filtered_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      case ($urandom_range(0, 19))
         0, 1:    return SIZE_W'($urandom_range(0, 2));      // acts as 3
         2:       return SIZE_W'($urandom_range(1025, 2047)); // acts as maximum
         3:       return SIZE_W'($urandom_range(13, 64));
         default: return SIZE_W'($urandom_range(3, 12));
      endcase
   endfunction

   task automatic queue_random(input int unsigned n);
      repeat (n) pixel_backlog.push_back(rand_pixel());
   endtask

   initial begin
      logic [PIX_W-1:0]  sobel_y_edge[9];
      logic [PIX_W-1:0]  laplace_peak[9];
      logic [PIX_W-1:0]  laplace_pit[9];
      logic [MODE_W-1:0] mode_sweep[8];
      int unsigned       random_sent;
      int unsigned       n;

      sobel_y_edge = '{8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255};
      laplace_peak = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
      laplace_pit  = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
      mode_sweep   = '{MODE_PREWITT_X, MODE_PREWITT_Y, MODE_SOBEL_X, MODE_SOBEL_Y,
                       MODE_LAPLACE, MODE_GAUSS, MODE_BOX, MODE_UNUSED};
      random_sent = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: spare index, undersized width, Sobel Y full-scale edge
      write_csr(CSR_UNUSED_INDEX, 11'h7FF);
      write_csr(CSR_IMAGE_WIDTH, 11'd0);
      write_csr(CSR_IMAGE_HEIGHT, 11'd3);
      write_csr(CSR_FILTER_MODE, SIZE_W'(MODE_SOBEL_Y));
      foreach (sobel_y_edge[i]) pixel_backlog.push_back(sobel_y_edge[i]);
      wait_drained();

      // Directed: Laplace saturating high and low
      write_csr(CSR_FILTER_MODE, SIZE_W'(MODE_LAPLACE));
      foreach (laplace_peak[i]) pixel_backlog.push_back(laplace_peak[i]);
      foreach (laplace_pit[i]) pixel_backlog.push_back(laplace_pit[i]);
      wait_drained();

      // Two narrow rows, then one widest row with width above the maximum;
      // the wide row runs through every mode and reads unwritten columns
      write_csr(CSR_IMAGE_WIDTH, 11'd3);
      write_csr(CSR_IMAGE_HEIGHT, 11'h7FF);
      queue_random(6);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, 11'h7FF);
      foreach (mode_sweep[i]) begin
         write_csr(CSR_FILTER_MODE, SIZE_W'(mode_sweep[i]));
         queue_random(MAX_WIDTH / 8);
         wait_drained();
      end

      // Exact maximum sizes, then back to small frames mid-frame
      write_csr(CSR_IMAGE_WIDTH, 11'd1024);
      write_csr(CSR_IMAGE_HEIGHT, 11'd1024);
      queue_random(30);
      wait_drained();

      // Random phases: sizes, modes and stall rates change between drains
      while (random_sent < RANDOM_PIXELS) begin
         if ($urandom_range(0, 1)) write_csr(CSR_IMAGE_WIDTH, rand_size());
         if ($urandom_range(0, 1)) write_csr(CSR_IMAGE_HEIGHT, rand_size());
         if ($urandom_range(0, 2) != 0) write_csr(CSR_FILTER_MODE, SIZE_W'($urandom_range(0, 2047)));
         send_gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
         recv_stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
         n = $urandom_range(10, 120);
         queue_random(n);
         random_sent += n;
         wait_drained();
      end

      // Closing stretch at full rate
      send_gap_odds = 0;
      recv_stall_odds = 0;
      send_gap = 0;
      recv_stall = 0;
      write_csr(CSR_IMAGE_WIDTH, 11'd7);
      write_csr(CSR_IMAGE_HEIGHT, 11'd5);
      write_csr(CSR_FILTER_MODE, SIZE_W'(MODE_PREWITT_X));
      queue_random(60);
      wait_drained();

      if (failures == 0)
         $display("conv3x3_image_filter_core_tb: PASS");
      else
         $display("conv3x3_image_filter_core_tb: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/c3f_pkg.sv
rtl/c3f_queue.sv
rtl/c3f_front.sv
rtl/c3f_back.sv
rtl/conv3x3_image_filter_core.sv
rtl/c3f_checker.sv
bench/conv3x3_image_filter_core_tb.sv
